// ===== rtl/ostt_pkg.sv =====
// Shared types and constants for the one-shot timer table.
// Used by ostt_dec_unit, ostt_slot_mem and one_shot_timer_table.
package ostt_pkg;

  localparam int DelayW      = 32;
  localparam int TagW        = 8;
  localparam int SlotW       = 3;
  localparam int MaxResults  = 8;
  localparam int ResCntW     = 4;
  localparam int SlotsDefault = 8;

  // input selector (in_tuser)
  localparam logic CmdStart = 1'b0;
  localparam logic CmdTick  = 1'b1;

  typedef enum logic [1:0] {
    KindStarted = 2'd0,
    KindFull    = 2'd1,
    KindExpired = 2'd2,
    KindIdle    = 2'd3
  } kind_t;

  // result of the shared decrement unit
  typedef struct packed {
    logic [DelayW-1:0] cnt_nxt;
    logic              zero;
  } dec_res_t;

  // write request into the slot store
  typedef struct packed {
    logic              cnt_we;
    logic              tag_we;
    logic [DelayW-1:0] cnt;
    logic [TagW-1:0]   tag;
  } mem_wr_t;

endpackage

// ===== rtl/ostt_dec_unit.sv =====
// Shared saturating decrement with zero detect, used once per active slot visited on a tick.
// Depends on ostt_pkg.
module ostt_dec_unit (
  input  logic [ostt_pkg::DelayW-1:0] cnt,
  output ostt_pkg::dec_res_t          res
);

  logic cnt_is_zero;

  assign cnt_is_zero = (cnt == '0);
  assign res.cnt_nxt = cnt_is_zero ? cnt : (cnt - 1'b1);
  // count is zero after this tick
  assign res.zero    = (res.cnt_nxt == '0);

endmodule

// ===== rtl/ostt_slot_mem.sv =====
// Per-slot count and tag store: one write port, one registered read port.
// Depends on ostt_pkg.
module ostt_slot_mem #(
  parameter int SLOTS = ostt_pkg::SlotsDefault,
  parameter int IdxW  = 3
) (
  input  logic                        clk,
  input  logic [IdxW-1:0]             wr_addr,
  input  ostt_pkg::mem_wr_t           wr,
  input  logic [IdxW-1:0]             rd_addr,
  output logic [ostt_pkg::DelayW-1:0] rd_cnt,
  output logic [ostt_pkg::TagW-1:0]   rd_tag
);

  logic [ostt_pkg::DelayW-1:0] cnt_mem [SLOTS];
  logic [ostt_pkg::TagW-1:0]   tag_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.cnt_we) begin
      cnt_mem[wr_addr] <= wr.cnt;
    end
    if (wr.tag_we) begin
      tag_mem[wr_addr] <= wr.tag;
    end
    rd_cnt <= cnt_mem[rd_addr];
    rd_tag <= tag_mem[rd_addr];
  end

endmodule

// ===== rtl/one_shot_timer_table.sv =====
// One-shot timer table: SLOTS countdown timers walked by a slot sequencer.
// Depends on ostt_pkg, ostt_dec_unit and ostt_slot_mem.
//
// Input beat (in_*): in_tuser selects start (0) or tick (1). A start beat
// carries the delay and tag in in_tdata and yields one beat: the claimed
// slot, or "table full". A tick beat yields one beat per expired timer
// (slot and tag, at most eight), or a single "no expiry" beat; out_tlast
// marks the final beat caused by each input beat.
// The sequencer visits one slot per cycle for a start; for a tick it
// visits each slot in S_RD (registered store read) and each active slot
// again in S_EXEC (the shared decrement), where it can hold as below.
// in_tready is high only between items.
// The result register lets the walk run on while a beat waits; when the
// receiver stalls and a further beat must be handed over, the walk holds
// on the current slot until out_tready returns.
// Reset clears the active flags (all timers free) and the channel state;
// no clearing pass is needed.
module one_shot_timer_table #(
  parameter int SLOTS = ostt_pkg::SlotsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // [31:0] delay_ticks, [39:32] task_tag
  input  logic        in_tuser,  // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // [2:0] slot, [10:3] expired_tag, [15:11] zero
  output logic [1:0]  out_tuser, // [1:0] kind
  output logic        out_tlast  // last
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam int DW = ostt_pkg::DelayW;
  localparam int TW = ostt_pkg::TagW;
  localparam int SW = ostt_pkg::SlotW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_RD,
    S_EXEC,
    S_LAST
  } state_t;

  state_t                        state_r;
  logic [IdxW-1:0]               idx_r;
  logic [SLOTS-1:0]              active_r;
  logic [DW-1:0]                 delay_r;
  logic [TW-1:0]                 tag_r;
  logic [ostt_pkg::ResCntW-1:0]  n_r;

  // held-back result: the final one gets tlast
  logic                          pend_v_r;
  ostt_pkg::kind_t               pend_kind_r;
  logic [SW-1:0]                 pend_slot_r;
  logic [TW-1:0]                 pend_tag_r;

  logic                          out_valid_r;
  ostt_pkg::kind_t               out_kind_r;
  logic [SW-1:0]                 out_slot_r;
  logic [TW-1:0]                 out_tag_r;
  logic                          out_last_r;

  logic [DW-1:0]                 rd_cnt;
  logic [TW-1:0]                 rd_tag;
  ostt_pkg::dec_res_t            dec_res;
  ostt_pkg::mem_wr_t             mem_wr;
  logic [SW-1:0]                 idx_slot;
  logic                          out_free;
  logic                          expire;
  logic                          exec_go;
  logic                          out_load;
  logic                          in_fire;

  generate
    if (IdxW >= SW) begin : g_slot_trunc
      assign idx_slot = idx_r[SW-1:0];
    end else begin : g_slot_ext
      assign idx_slot = {{(SW-IdxW){1'b0}}, idx_r};
    end
  endgenerate

  ostt_slot_mem #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_mem (
    .clk     (clk),
    .wr_addr (idx_r),
    .wr      (mem_wr),
    .rd_addr (idx_r),
    .rd_cnt  (rd_cnt),
    .rd_tag  (rd_tag)
  );

  ostt_dec_unit u_dec (
    .cnt (rd_cnt),
    .res (dec_res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign expire    = dec_res.zero && (n_r < ostt_pkg::ResCntW'(ostt_pkg::MaxResults));
  // an earlier expiry must leave through the result register first
  assign exec_go   = !(expire && pend_v_r) || out_free;
  // a beat enters the result register
  assign out_load  = (state_r == S_EXEC && exec_go && expire && pend_v_r) ||
                     (state_r == S_LAST && out_free);

  always_comb begin
    mem_wr = '0;
    if (state_r == S_FIND && !active_r[idx_r]) begin
      mem_wr.cnt_we = 1'b1;
      mem_wr.tag_we = 1'b1;
      mem_wr.cnt    = delay_r;
      mem_wr.tag    = tag_r;
    end else if (state_r == S_EXEC && exec_go) begin
      mem_wr.cnt_we = 1'b1;
      mem_wr.cnt    = dec_res.cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      active_r    <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            delay_r  <= in_tdata[DW-1:0];
            tag_r    <= in_tdata[DW+TW-1:DW];
            idx_r    <= '0;
            n_r      <= '0;
            pend_v_r <= 1'b0;
            state_r  <= (in_tuser == ostt_pkg::CmdStart) ? S_FIND : S_RD;
          end
        end
        S_FIND: begin
          if (!active_r[idx_r]) begin
            active_r[idx_r] <= 1'b1;
            pend_v_r        <= 1'b1;
            pend_kind_r     <= ostt_pkg::KindStarted;
            pend_slot_r     <= idx_slot;
            pend_tag_r      <= '0;
            state_r         <= S_LAST;
          end else if (idx_r == LastIdx) begin
            pend_v_r    <= 1'b1;
            pend_kind_r <= ostt_pkg::KindFull;
            pend_slot_r <= '0;
            pend_tag_r  <= '0;
            state_r     <= S_LAST;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_RD: begin
          // store read of idx_r is under way; data arrives in S_EXEC
          if (active_r[idx_r]) begin
            state_r <= S_EXEC;
          end else if (idx_r == LastIdx) begin
            state_r <= S_LAST;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            if (expire) begin
              if (pend_v_r) begin
                out_kind_r  <= pend_kind_r;
                out_slot_r  <= pend_slot_r;
                out_tag_r   <= pend_tag_r;
                out_last_r  <= 1'b0;
              end
              active_r[idx_r] <= 1'b0;
              pend_v_r        <= 1'b1;
              pend_kind_r     <= ostt_pkg::KindExpired;
              pend_slot_r     <= idx_slot;
              pend_tag_r      <= rd_tag;
              n_r             <= n_r + 1'b1;
            end
            if (idx_r == LastIdx) begin
              state_r <= S_LAST;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_LAST: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            if (pend_v_r) begin
              out_kind_r <= pend_kind_r;
              out_slot_r <= pend_slot_r;
              out_tag_r  <= pend_tag_r;
            end else begin
              out_kind_r <= ostt_pkg::KindIdle;
              out_slot_r <= '0;
              out_tag_r  <= '0;
            end
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_tag_r, out_slot_r};

  // a claimed slot is marked busy on the next cycle
  a_claim_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND && !active_r[idx_r]) |=> active_r[$past(idx_r)])
    else $error("claimed slot not marked active");

  // an expiring slot is freed
  a_expire_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && exec_go && expire) |=> !active_r[$past(idx_r)])
    else $error("expired slot still active");

  a_expiry_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= ostt_pkg::ResCntW'(ostt_pkg::MaxResults))
    else $error("too many expiries in one tick");

  // start, full and no-expiry results stand alone
  a_single_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != ostt_pkg::KindExpired) |-> out_last_r)
    else $error("single-beat result without last");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for one_shot_timer_table: start and tick beats in, result beats out.
// Depends on ostt_pkg and the one_shot_timer_table RTL with its submodules; needs no other files.

module tb;

  localparam int SLOTS = 8;

  typedef struct packed {
    ostt_pkg::kind_t            kind;
    logic [ostt_pkg::SlotW-1:0] slot;
    logic [ostt_pkg::TagW-1:0]  tag;
    logic                       last;
  } timer_beat_t;

  // Tracks the timer slots and the result beats still owed by the DUT.
  class slot_table_tracker;
    bit                          active [SLOTS];
    logic [ostt_pkg::DelayW-1:0] count  [SLOTS];
    logic [ostt_pkg::TagW-1:0]   tag    [SLOTS];
    timer_beat_t                 due_beats[$];
    int                          errors;

    function timer_beat_t make_beat(ostt_pkg::kind_t k, int s,
                                    logic [ostt_pkg::TagW-1:0] t, logic l);
      timer_beat_t b;
      b.kind = k;
      b.slot = s[ostt_pkg::SlotW-1:0];
      b.tag  = t;
      b.last = l;
      return b;
    endfunction

    function void apply_command(logic cmd, logic [ostt_pkg::DelayW-1:0] delay,
                                logic [ostt_pkg::TagW-1:0] t);
      timer_beat_t batch[$];
      timer_beat_t b;
      int          free_slot;
      free_slot = -1;
      if (cmd == ostt_pkg::CmdStart) begin
        for (int i = 0; i < SLOTS; i++)
          if (!active[i] && free_slot < 0) free_slot = i;
        if (free_slot >= 0) begin
          active[free_slot] = 1'b1;
          count[free_slot]  = delay;
          tag[free_slot]    = t;
          due_beats.push_back(make_beat(ostt_pkg::KindStarted, free_slot, '0, 1'b1));
        end else begin
          due_beats.push_back(make_beat(ostt_pkg::KindFull, 0, '0, 1'b1));
        end
      end else begin
        // one tick: count down in slot order, expire whatever reaches zero
        for (int i = 0; i < SLOTS; i++) begin
          if (active[i]) begin
            if (count[i] != 0) count[i] = count[i] - 1;
            if (count[i] == 0 && batch.size() < ostt_pkg::MaxResults) begin
              batch.push_back(make_beat(ostt_pkg::KindExpired, i, tag[i], 1'b0));
              active[i] = 1'b0;
            end
          end
        end
        if (batch.size() == 0) begin
          due_beats.push_back(make_beat(ostt_pkg::KindIdle, 0, '0, 1'b1));
        end else begin
          b = batch.pop_back();
          b.last = 1'b1;
          batch.push_back(b);
          foreach (batch[i]) due_beats.push_back(batch[i]);
        end
      end
    endfunction

    task mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_beat(ostt_pkg::kind_t k, logic [ostt_pkg::SlotW-1:0] s,
                    logic [ostt_pkg::TagW-1:0] t, logic l, logic [4:0] pad);
      timer_beat_t e;
      if (due_beats.size() == 0) begin
        mismatch($sformatf("unexpected beat kind=%0d slot=%0d tag=%02h", k, s, t));
      end else begin
        e = due_beats.pop_front();
        if (k !== e.kind) mismatch($sformatf("kind exp %0d got %0d", e.kind, k));
        if (s !== e.slot) mismatch($sformatf("slot exp %0d got %0d", e.slot, s));
        if (t !== e.tag)  mismatch($sformatf("tag exp %02h got %02h", e.tag, t));
        if (l !== e.last) mismatch($sformatf("last exp %0b got %0b", e.last, l));
        if (pad !== 5'd0) mismatch($sformatf("tdata pad bits %b", pad));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // [31:0] delay_ticks, [39:32] task_tag
  logic        in_tuser = 1'b0; // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;      // [2:0] slot, [10:3] expired_tag, [15:11] zero
  logic [1:0]  out_tuser;      // [1:0] kind
  logic        out_tlast;

  slot_table_tracker tracker;
  bit                in_gaps = 1'b0;
  logic              out_stalls = 1'b0;
  int                stall_left = 0;

  logic [7:0] corner_tags [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'hFE};

  one_shot_timer_table #(.SLOTS(SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stall bursts, started only while out_stalls is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_tready <= 1'b1;
    end else if (out_stalls && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_beat(ostt_pkg::kind_t'(out_tuser), out_tdata[2:0], out_tdata[10:3],
                         out_tlast, out_tdata[15:11]);
  end

  task automatic drive_command(input logic cmd, input logic [31:0] delay,
                               input logic [7:0] tag);
    if (in_gaps && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {tag, delay};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.apply_command(cmd, delay, tag);
  endtask

  initial begin
    #2_000_000;
    $display("** one_shot_timer_table: FAILED **");
    $finish;
  end

  initial begin
    logic        cmd;
    logic [31:0] delay;
    int          pick;
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gaps = 1'b1;
    out_stalls <= 1'b1;

    // empty table: a tick expires nothing
    drive_command(ostt_pkg::CmdTick, 32'd0, 8'd0);
    // fill every slot with zero delay, then one start too many
    for (int i = 0; i < 8; i++) drive_command(ostt_pkg::CmdStart, 32'd0, corner_tags[i]);
    drive_command(ostt_pkg::CmdStart, 32'hFFFF_FFFF, 8'h33);
    // all eight expire on a single tick
    drive_command(ostt_pkg::CmdTick, 32'hFFFF_FFFF, 8'hFF);
    drive_command(ostt_pkg::CmdStart, 32'd1, 8'h11);
    drive_command(ostt_pkg::CmdStart, 32'd1, 8'h22);
    drive_command(ostt_pkg::CmdStart, 32'd2, 8'h44);
    // max delay: slot 3 stays busy for the rest of the run
    drive_command(ostt_pkg::CmdStart, 32'hFFFF_FFFF, 8'hC3);
    drive_command(ostt_pkg::CmdTick, 32'd0, 8'd0);
    drive_command(ostt_pkg::CmdTick, 32'd0, 8'd0);
    drive_command(ostt_pkg::CmdTick, 32'd0, 8'd0);

    for (int k = 0; k < 500; k++) begin
      if (k % 50 == 0) begin
        in_gaps = (k < 400) && ($urandom_range(0, 2) != 0);
        out_stalls <= (k < 400) && ($urandom_range(0, 2) != 0);
      end
      cmd = ($urandom_range(0, 99) < 48) ? ostt_pkg::CmdStart : ostt_pkg::CmdTick;
      pick = $urandom_range(0, 19);
      if (cmd == ostt_pkg::CmdTick) delay = $urandom;
      else if (pick < 16) delay = $urandom_range(0, 10);
      else if (pick < 19) delay = $urandom_range(11, 60);
      else delay = $urandom_range(61, 400);
      drive_command(cmd, delay, 8'($urandom_range(0, 255)));
    end
    in_tvalid <= 1'b0;

    while (tracker.due_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("** one_shot_timer_table: PASSED **");
    end else begin
      $display("** one_shot_timer_table: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ostt_pkg.sv
rtl/ostt_dec_unit.sv
rtl/ostt_slot_mem.sv
rtl/one_shot_timer_table.sv
sim/tb.sv
